// File: hw/rtl/dla_pkg.sv
package dla_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  localparam int ADDR_W = 32;
  localparam int MAC_W = 48;
  localparam int TIME_W = 48;
  localparam int CFG_IDX_W = 2;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_OFFER = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_NAK   = 2'd3;

  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECONDS = 2'd2;

  localparam logic [31:0] LEASE_SECONDS_RESET = 32'd3600;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    idx_t rd_addr;
    idx_t wr_addr;
    logic wr_mac;
    logic wr_exp;
    logic set_act;
  } store_cmd_t;

  typedef struct packed {
    logic             act;
    logic [MAC_W-1:0] mac;
    logic [TIME_W-1:0] expiry;
  } store_rd_t;

endpackage

// File: hw/rtl/dhcp_lease_allocator.sv
// Channel   Handshake                 Payload
// ------    ---------                 -------
// item      start & !busy             op, msg_code, client_mac, requested_addr, client_addr
// reply     reply_valid (one cycle)   reply_kind, reply_addr
// config    cfg_we                    cfg_index, cfg_data
//
// Every transaction gives one reply. A tick or ignored message type replies in the
// next cycle and leaves busy low. A discover or request scans the pool through the
// single lease store read port, one read state and one check state for each entry,
// and stops early when the client MAC is found. Reset clears all leases at once; no
// clearing pass. The receiver cannot stall.
module dhcp_lease_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [7:0]                      msg_code,
  input  logic [dla_pkg::MAC_W-1:0]       client_mac,
  input  logic [dla_pkg::ADDR_W-1:0]      requested_addr,
  input  logic [dla_pkg::ADDR_W-1:0]      client_addr,
  output logic                            reply_valid,
  output logic [1:0]                      reply_kind,
  output logic [dla_pkg::ADDR_W-1:0]      reply_addr,
  input  logic                            cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import dla_pkg::*;

  logic [ADDR_W-1:0] pool_first;
  logic [ADDR_W-1:0] pool_last;
  logic [31:0]       lease_seconds;
  logic [TIME_W-1:0] time_now;
  idx_t              last_idx;
  logic              pool_clear;
  logic [ADDR_W-1:0] span;
  logic [TIME_W-1:0] lease_end;
  store_cmd_t        cmd;
  store_rd_t         rd;
  logic [MAC_W-1:0]  mac_data;

  assign pool_clear = cfg_we && (cfg_index == CFG_POOL_FIRST || cfg_index == CFG_POOL_LAST);
  assign span       = (pool_last < pool_first) ? '0 : (pool_last - pool_first);
  assign lease_end  = time_now + TIME_W'(lease_seconds);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_first    <= '0;
      pool_last     <= '0;
      lease_seconds <= LEASE_SECONDS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_FIRST:    pool_first    <= cfg_data;
        CFG_POOL_LAST:     pool_last     <= cfg_data;
        CFG_LEASE_SECONDS: lease_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (start && !busy && !op) begin
      time_now <= time_now + 1'b1;
    end
  end

  // highest entry index in use, size capped at the table depth
  always_ff @(posedge clk) begin
    if (span >= ADDR_W'(POOL_DEPTH - 1)) begin
      last_idx <= IDX_W'(POOL_DEPTH - 1);
    end else begin
      last_idx <= span[IDX_W-1:0];
    end
  end

  dla_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .msg_code       (msg_code),
    .client_mac     (client_mac),
    .requested_addr (requested_addr),
    .client_addr    (client_addr),
    .pool_first     (pool_first),
    .last_idx       (last_idx),
    .time_now       (time_now),
    .rd             (rd),
    .cmd            (cmd),
    .mac_data       (mac_data),
    .reply_valid    (reply_valid),
    .reply_kind     (reply_kind),
    .reply_addr     (reply_addr)
  );

  dla_lease_store u_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (pool_clear),
    .cmd      (cmd),
    .mac_data (mac_data),
    .exp_data (lease_end),
    .rd       (rd)
  );

endmodule

// File: hw/rtl/dla_lease_store.sv
module dla_lease_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  dla_pkg::store_cmd_t       cmd,
  input  logic [dla_pkg::MAC_W-1:0] mac_data,
  input  logic [dla_pkg::TIME_W-1:0] exp_data,
  output dla_pkg::store_rd_t        rd
);
  import dla_pkg::*;

  logic [POOL_DEPTH-1:0] active;
  logic [MAC_W-1:0]      mem_mac [POOL_DEPTH];
  logic [TIME_W-1:0]     mem_exp [POOL_DEPTH];

  // valid bits, cleared by reset and by any pool write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      active <= '0;
    end else if (cmd.set_act) begin
      active[cmd.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_mac) begin
      mem_mac[cmd.wr_addr] <= mac_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_exp) begin
      mem_exp[cmd.wr_addr] <= exp_data;
    end
  end

  always_ff @(posedge clk) begin
    rd.act    <= active[cmd.rd_addr];
    rd.mac    <= mem_mac[cmd.rd_addr];
    rd.expiry <= mem_exp[cmd.rd_addr];
  end

endmodule

// File: hw/rtl/dla_ctrl.sv
module dla_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [7:0]                  msg_code,
  input  logic [dla_pkg::MAC_W-1:0]   client_mac,
  input  logic [dla_pkg::ADDR_W-1:0]  requested_addr,
  input  logic [dla_pkg::ADDR_W-1:0]  client_addr,
  input  logic [dla_pkg::ADDR_W-1:0]  pool_first,
  input  dla_pkg::idx_t               last_idx,
  input  logic [dla_pkg::TIME_W-1:0]  time_now,
  input  dla_pkg::store_rd_t          rd,
  output dla_pkg::store_cmd_t         cmd,
  output logic [dla_pkg::MAC_W-1:0]   mac_data,
  output logic                        reply_valid,
  output logic [1:0]                  reply_kind,
  output logic [dla_pkg::ADDR_W-1:0]  reply_addr
);
  import dla_pkg::*;

  state_t state, state_next;
  idx_t   idx, idx_next;
  idx_t   sel, sel_next;
  idx_t   free_idx, free_idx_next;
  logic   found, found_next;
  logic   claim, claim_next;
  logic   free_found, free_found_next;
  logic   is_req, is_req_next;
  logic [MAC_W-1:0]  mac, mac_next;
  logic [ADDR_W-1:0] req_addr, req_addr_next;
  logic              reply_valid_next;
  logic [1:0]        reply_kind_next;
  logic [ADDR_W-1:0] reply_addr_next;

  logic              accept;
  logic              match_hit;
  logic              free_hit;
  logic [ADDR_W-1:0] entry_addr;
  logic              addr_match;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign mac_data   = mac;

  // shared compare unit: one entry per read/check pair
  assign match_hit  = rd.act && (rd.mac == mac);
  assign free_hit   = !rd.act || (time_now > rd.expiry);
  assign entry_addr = pool_first + ADDR_W'(sel);
  assign addr_match = (entry_addr == req_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      reply_valid <= 1'b0;
    end else begin
      state       <= state_next;
      reply_valid <= reply_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    sel        <= sel_next;
    free_idx   <= free_idx_next;
    found      <= found_next;
    claim      <= claim_next;
    free_found <= free_found_next;
    is_req     <= is_req_next;
    mac        <= mac_next;
    req_addr   <= req_addr_next;
    reply_kind <= reply_kind_next;
    reply_addr <= reply_addr_next;
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    sel_next         = sel;
    free_idx_next    = free_idx;
    found_next       = found;
    claim_next       = claim;
    free_found_next  = free_found;
    is_req_next      = is_req;
    mac_next         = mac;
    req_addr_next    = req_addr;
    reply_valid_next = 1'b0;
    reply_kind_next  = reply_kind;
    reply_addr_next  = reply_addr;
    cmd.rd_addr      = idx;
    cmd.wr_addr      = sel;
    cmd.wr_mac       = 1'b0;
    cmd.wr_exp       = 1'b0;
    cmd.set_act      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mac_next        = client_mac;
          req_addr_next   = (requested_addr == '0) ? client_addr : requested_addr;
          is_req_next     = (msg_code == MSG_REQUEST);
          idx_next        = '0;
          found_next      = 1'b0;
          claim_next      = 1'b0;
          free_found_next = 1'b0;
          if (op && (msg_code == MSG_DISCOVER || msg_code == MSG_REQUEST)) begin
            state_next = ST_READ;
          end else begin
            reply_valid_next = 1'b1;
            reply_kind_next  = KIND_NONE;
            reply_addr_next  = '0;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (match_hit) begin
          sel_next   = idx;
          found_next = 1'b1;
          claim_next = 1'b0;
          state_next = ST_COMMIT;
        end else begin
          if (free_hit && !free_found) begin
            free_idx_next   = idx;
            free_found_next = 1'b1;
          end
          if (idx == last_idx) begin
            found_next = free_found || free_hit;
            claim_next = free_found || free_hit;
            sel_next   = free_found ? free_idx : idx;
            state_next = ST_COMMIT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_COMMIT: begin
        cmd.wr_mac       = found && claim;
        cmd.set_act      = found && claim;
        cmd.wr_exp       = found && (claim || (is_req && addr_match));
        reply_valid_next = 1'b1;
        state_next       = ST_IDLE;
        if (is_req) begin
          reply_kind_next = (found && addr_match) ? KIND_ACK : KIND_NAK;
          reply_addr_next = req_addr;
        end else if (found) begin
          reply_kind_next = KIND_OFFER;
          reply_addr_next = entry_addr;
        end else begin
          reply_kind_next = KIND_NONE;
          reply_addr_next = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_reply_when_idle: assert property (@(posedge clk) disable iff (rst)
    reply_valid |-> !busy)
    else $error("reply strobe while busy");

  a_tick_replies_next: assert property (@(posedge clk) disable iff (rst)
    (accept && !op) |=> (reply_valid && reply_kind == KIND_NONE))
    else $error("tick transaction did not reply in the next cycle");

  a_claim_sets_active: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_mac |-> (cmd.set_act && cmd.wr_exp))
    else $error("claim without active and expiry write");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ($past(state) == ST_READ))
    else $error("entry checked without a preceding read");

  a_offer_from_commit: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind != KIND_NONE) |-> ($past(state) == ST_COMMIT))
    else $error("reply issued outside commit");

endmodule

// File: tb/dhcp_lease_allocator_test.sv
module dhcp_lease_allocator_test;
  import dla_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MSG = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CLIENTS = 10;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 67;
  localparam int WATCHDOG = 4000;

  localparam logic [47:0] MAC_LO = 48'h0000_0000_0000;
  localparam logic [47:0] MAC_HI = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAC_MID = 48'h021A_5C77_90E3;

  typedef struct {
    logic        op;
    logic [7:0]  msg;
    logic [47:0] mac;
    logic [31:0] req;
    logic [31:0] ci;
  } item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
  } reply_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] sel;
    logic [31:0]          val;
    item_t                it;
    bit                   typed;
    logic [1:0]           k;
    logic [31:0]          a;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 op;
  logic [7:0]           msg_code;
  logic [MAC_W-1:0]     client_mac;
  logic [ADDR_W-1:0]    requested_addr;
  logic [ADDR_W-1:0]    client_addr;
  logic                 reply_valid;
  logic [1:0]           reply_kind;
  logic [ADDR_W-1:0]    reply_addr;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // lease table mirror
  logic        lease_on    [POOL_DEPTH];
  logic [47:0] lease_owner [POOL_DEPTH];
  logic [47:0] lease_end   [POOL_DEPTH];
  logic [47:0] clock_s;
  logic [31:0] first_addr;
  logic [31:0] last_addr;
  logic [31:0] lease_len;

  reply_t replies_due[$];
  row_t   plan[$];
  int     mismatches = 0;
  int     idle_pct = 0;
  int     quiet = 0;

  dhcp_lease_allocator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pool_entries();
    logic [31:0] top;
    logic [32:0] n;
    top = (last_addr < first_addr) ? first_addr : last_addr;
    n = {1'b0, top} - {1'b0, first_addr} + 33'd1;
    return (n > POOL_DEPTH) ? POOL_DEPTH : int'(n);
  endfunction

  function automatic void drop_leases();
    foreach (lease_on[i]) lease_on[i] = 1'b0;
  endfunction

  function automatic int claim_entry(logic [47:0] mac);
    int n;
    n = pool_entries();
    for (int i = 0; i < n; i++)
      if (lease_on[i] && lease_owner[i] == mac) return i;
    for (int i = 0; i < n; i++) begin
      if (!lease_on[i] || clock_s > lease_end[i]) begin
        lease_owner[i] = mac;
        lease_on[i] = 1'b1;
        lease_end[i] = clock_s + lease_len;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void decide_reply(input item_t it, output logic [1:0] kind,
                                       output logic [31:0] addr);
    int slot;
    logic [31:0] want_addr;
    kind = KIND_NONE;
    addr = '0;
    if (it.op == OP_TICK) begin
      clock_s = clock_s + 48'd1;
    end else if (it.msg == MSG_DISCOVER) begin
      slot = claim_entry(it.mac);
      if (slot >= 0) begin
        kind = KIND_OFFER;
        addr = first_addr + 32'(slot);
      end
    end else if (it.msg == MSG_REQUEST) begin
      want_addr = (it.req != '0) ? it.req : it.ci;
      slot = claim_entry(it.mac);
      addr = want_addr;
      if (slot >= 0 && first_addr + 32'(slot) == want_addr) begin
        lease_end[slot] = clock_s + lease_len;
        kind = KIND_ACK;
      end else begin
        kind = KIND_NAK;
      end
    end
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: reply %s mismatch, got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reply_t due;
    if (!rst && reply_valid) begin
      if (replies_due.size() == 0) begin
        flag("without transaction", {30'd0, reply_kind}, reply_addr);
      end else begin
        due = replies_due.pop_front();
        if (reply_kind !== due.kind) flag("kind", {30'd0, reply_kind}, {30'd0, due.kind});
        if (reply_addr !== due.addr) flag("addr", reply_addr, due.addr);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || reply_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input item_t it, input bit typed, input logic [1:0] tk,
                           input logic [31:0] ta, output logic [1:0] kind,
                           output logic [31:0] addr);
    reply_t due;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    op <= it.op;
    msg_code <= it.msg;
    client_mac <= it.mac;
    requested_addr <= it.req;
    client_addr <= it.ci;
    do @(posedge clk); while (busy);
    decide_reply(it, kind, addr);
    due.kind = typed ? tk : kind;
    due.addr = typed ? ta : addr;
    replies_due.push_back(due);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // caller lowers cfg_we once the last register is written
  task automatic set_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      CFG_POOL_FIRST: begin
        first_addr = val;
        drop_leases();
      end
      CFG_POOL_LAST: begin
        last_addr = val;
        drop_leases();
      end
      CFG_LEASE_SECONDS: lease_len = val;
      default: ;
    endcase
  endtask

  function automatic row_t ask(logic o, logic [7:0] t, logic [47:0] m, logic [31:0] r,
                               logic [31:0] c);
    row_t row;
    row = '{default: '0};
    row.it = '{op: o, msg: t, mac: m, req: r, ci: c};
    return row;
  endfunction

  function automatic row_t ask_known(logic o, logic [7:0] t, logic [47:0] m,
                                     logic [31:0] r, logic [31:0] c, logic [1:0] k,
                                     logic [31:0] a);
    row_t row;
    row = ask(o, t, m, r, c);
    row.typed = 1'b1;
    row.k = k;
    row.a = a;
    return row;
  endfunction

  function automatic row_t write_reg(logic [CFG_IDX_W-1:0] sel, logic [31:0] val);
    row_t row;
    row = ask(OP_TICK, 8'd0, '0, '0, '0);
    row.is_reg = 1'b1;
    row.sel = sel;
    row.val = val;
    return row;
  endfunction

  function automatic void build_plan();
    // after reset: one entry at address 0
    plan.push_back(ask_known(OP_TICK, 8'h00, MAC_LO, '0, '0, KIND_NONE, '0));
    plan.push_back(ask_known(OP_MSG, 8'h00, MAC_MID, '0, '0, KIND_NONE, '0));
    plan.push_back(ask_known(OP_MSG, 8'hFF, MAC_MID, '1, '1, KIND_NONE, '0));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_LO, '1, '1, KIND_OFFER, '0));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_HI, '0, '0, KIND_NONE, '0));
    plan.push_back(ask_known(OP_MSG, MSG_REQUEST, MAC_HI, '0, '0, KIND_NAK, '0));
    plan.push_back(ask_known(OP_MSG, MSG_REQUEST, MAC_LO, '0, '0, KIND_ACK, '0));
    plan.push_back(ask_known(OP_MSG, MSG_REQUEST, MAC_LO, '1, '0, KIND_NAK, '1));
    plan.push_back(ask_known(OP_MSG, MSG_REQUEST, MAC_LO, '0, '1, KIND_NAK, '1));
    plan.push_back(ask_known(OP_TICK, MSG_DISCOVER, MAC_HI, '1, '1, KIND_NONE, '0));
    // top of the address space, zero-length leases
    plan.push_back(write_reg(CFG_LEASE_SECONDS, '0));
    plan.push_back(write_reg(CFG_POOL_FIRST, 32'hFFFF_FFFC));
    plan.push_back(write_reg(CFG_POOL_LAST, '1));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_LO, '0, '0, KIND_OFFER, 32'hFFFF_FFFC));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_HI, '0, '0, KIND_OFFER, 32'hFFFF_FFFD));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_LO, '0, '0, KIND_OFFER, 32'hFFFF_FFFC));
    plan.push_back(ask(OP_TICK, 8'h00, MAC_LO, '0, '0));
    plan.push_back(ask(OP_MSG, MSG_DISCOVER, MAC_MID, '0, '0));
    plan.push_back(ask(OP_MSG, MSG_REQUEST, MAC_LO, 32'hFFFF_FFFC, '0));
    plan.push_back(ask(OP_MSG, MSG_REQUEST, MAC_HI, '0, 32'hFFFF_FFFD));
    // last below first: a single entry
    plan.push_back(write_reg(CFG_LEASE_SECONDS, '1));
    plan.push_back(write_reg(CFG_SPARE, '1));
    plan.push_back(write_reg(CFG_POOL_LAST, '0));
    plan.push_back(ask_known(OP_MSG, MSG_REQUEST, MAC_MID, 32'hFFFF_FFFC, '0,
                             KIND_ACK, 32'hFFFF_FFFC));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_HI, '0, '0, KIND_NONE, '0));
    // whole address space, capped at the table depth
    plan.push_back(write_reg(CFG_POOL_FIRST, '0));
    plan.push_back(write_reg(CFG_POOL_LAST, '1));
    plan.push_back(ask_known(OP_MSG, MSG_DISCOVER, MAC_HI, '0, '0, KIND_OFFER, '0));
    plan.push_back(ask(OP_MSG, MSG_REQUEST, MAC_MID, '0, 32'd1));
    plan.push_back(ask(OP_MSG, MSG_REQUEST, MAC_LO, 32'h0000_00FF, '0));
  endfunction

  initial begin
    bit          writing;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] lease;
    logic [47:0] clients [CLIENTS];
    logic [31:0] offered [CLIENTS];
    item_t       it;
    int          span;
    int          done;
    int          c;
    int          roll;
    int          pick;

    writing = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    op <= 1'b0;
    msg_code <= '0;
    client_mac <= '0;
    requested_addr <= '0;
    client_addr <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drop_leases();
    clock_s = '0;
    first_addr = '0;
    last_addr = '0;
    lease_len = LEASE_SECONDS_RESET;
    @(posedge clk);

    build_plan();
    foreach (plan[r]) begin
      if (plan[r].is_reg) begin
        if (!writing) begin
          quiesce();
          writing = 1'b1;
        end
        set_reg(plan[r].sel, plan[r].val);
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        send_item(plan[r].it, plan[r].typed, plan[r].k, plan[r].a, kind, addr);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      idle_pct = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 30 : 0;
      // some phases keep the leases and only change their length
      if (ph != 3 && ph != 7) begin
        if (ph == 5) begin
          lo = $urandom;
          hi = '1;
        end else begin
          span = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: lo = '0;
            1: lo = 32'hFFFF_FFFF - 32'(span) + 32'd1;
            default: lo = $urandom;
          endcase
          hi = lo + 32'(span) - 32'd1;
          if (hi < lo) hi = '1;
          if ($urandom_range(0, 5) == 0) hi = lo - 32'($urandom_range(1, 1000));
        end
        set_reg(CFG_POOL_FIRST, lo);
        set_reg(CFG_POOL_LAST, hi);
      end
      case ($urandom_range(0, 6))
        0: lease = '0;
        1: lease = 32'd1;
        2: lease = 32'd3;
        3: lease = 32'd10;
        4: lease = 32'd60;
        5: lease = '1;
        default: lease = $urandom;
      endcase
      set_reg(CFG_LEASE_SECONDS, lease);
      cfg_we <= 1'b0;

      for (int i = 0; i < CLIENTS; i++) begin
        clients[i] = 48'({$urandom, $urandom});
        offered[i] = first_addr + 32'(i);
      end
      if (ph == 2) clients[0] = MAC_LO;
      if (ph == 4) clients[1] = MAC_HI;

      done = 0;
      while (done < PHASE_ITEMS) begin
        c = $urandom_range(0, CLIENTS - 1);
        it.op = OP_MSG;
        it.mac = clients[c];
        it.req = $urandom;
        it.ci = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          it.op = OP_TICK;
          it.msg = 8'($urandom);
        end else if (roll < 30) begin
          it.msg = 8'($urandom);
          if ($urandom_range(0, 1) == 1) it.mac = 48'({$urandom, $urandom});
        end else if (roll < 62) begin
          it.msg = MSG_DISCOVER;
        end else begin
          it.msg = MSG_REQUEST;
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            it.req = offered[c];
          end else if (pick < 8) begin
            it.req = '0;
            it.ci = offered[c];
          end else if (pick == 8) begin
            it.req = first_addr + 32'($urandom_range(0, 15));
          end
        end
        send_item(it, 1'b0, KIND_NONE, '0, kind, addr);
        if (kind == KIND_OFFER || kind == KIND_ACK) offered[c] = addr;
        if (it.op == OP_TICK || it.msg == MSG_DISCOVER || it.msg == MSG_REQUEST) done++;
      end
    end

    idle_pct = 0;
    quiesce();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
